### design/circular_fifo_with_peek_unit_defines.svh
// Assertion macros shared by the circular FIFO with peek RTL.
`ifndef CIRCULAR_FIFO_WITH_PEEK_UNIT_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_PEEK_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CFWP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Check that cons holds in the cycle after ante.
`define CFWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

### design/cfwp_pkg.sv
// Types and constants of the circular FIFO with peek.
package cfwp_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int WORD_W         = 32;
	localparam int CAP_W          = 5;
	localparam int FILL_W         = 5;
	localparam int POS_W          = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_PEEK  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_EMPTY   = 2'd2,
		STATUS_BAD_POS = 2'd3
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [WORD_W-1:0]  write_value;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0]  read_data;
		status_t            status;
		logic [FILL_W-1:0]  fill_count;
		logic               is_full;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic sel;
	} cell_ctrl_t;

endpackage

### design/circular_fifo_with_peek_unit.sv
// Top level of the circular FIFO with peek: control, cell chain and result register.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation per item:
//   write, read, peek at a 1-based position from the oldest entry, or clear.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one result per item with
//   the data, status, fill count and full flag after the operation.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the capacity in use;
//   every such write empties the FIFO. cfg_ready is always high.
// Result and throughput:
//   The result of an item is registered and appears in the cycle after it is
//   accepted. One item per cycle is sustained while rsp_ready stays high; the
//   whole operation, including the shift of the cell chain on a read, completes in the accept cycle.
// Reset:
//   arst_n empties the FIFO, drops rsp_valid and sets the capacity to 10.
// Stall:
//   While rsp_valid is high and rsp_ready is low the result is held and
//   req_ready is low; a new item is taken in the cycle the result leaves.
`include "circular_fifo_with_peek_unit_defines.svh"

module circular_fifo_with_peek_unit #(
	parameter int DEPTH      = cfwp_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cfwp_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  cfwp_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output cfwp_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cfwp_pkg::CAP_W-1:0]   cfg_data
);

	localparam int NCELL = (DEPTH < 31) ? DEPTH : 31;
	localparam int SW    = (DATA_WIDTH < cfwp_pkg::WORD_W) ? DATA_WIDTH : cfwp_pkg::WORD_W;

	logic [cfwp_pkg::CAP_W-1:0]  cap_q;
	logic [cfwp_pkg::FILL_W-1:0] fill_q;
	logic [cfwp_pkg::FILL_W-1:0] fill_nxt;
	logic [cfwp_pkg::FILL_W-1:0] cap_eff;
	logic                        rsp_valid_q;
	cfwp_pkg::rsp_t              rsp_q;
	cfwp_pkg::rsp_t              rsp_nxt;
	logic                        accept;
	logic                        cfg_accept;
	logic                        wr_ok;
	logic                        rd_ok;
	logic                        clr;
	logic [SW-1:0]               peek_word;
	logic [SW-1:0]               write_word;
	logic [SW-1:0]               words [NCELL];
	logic [SW-1:0]               taps  [NCELL];
	cfwp_pkg::cell_ctrl_t        ctrls [NCELL];

	assign req_ready  = !rsp_valid_q || rsp_ready;
	assign accept     = req_valid && req_ready;
	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;
	assign write_word = req.write_value[SW-1:0];

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = cfwp_pkg::FILL_W'(1);
		end else if (32'(cap_q) > NCELL) begin
			cap_eff = cfwp_pkg::FILL_W'(NCELL);
		end else begin
			cap_eff = cap_q;
		end
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		assign ctrls[i].load  = accept && wr_ok && (fill_q == cfwp_pkg::FILL_W'(i));
		assign ctrls[i].shift = accept && rd_ok;
		assign ctrls[i].sel   = (req.position == cfwp_pkg::POS_W'(i + 1));

		cfwp_cell #(
			.WIDTH(SW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrls[i]),
			.write_word(write_word),
			.next_word ((i == NCELL - 1) ? words[i] : words[(i + 1) % NCELL]),
			.word      (words[i]),
			.tap       (taps[i])
		);
	end

	always_comb begin
		peek_word = '0;
		for (int i = 0; i < NCELL; i++) begin
			peek_word = peek_word | taps[i];
		end
	end

	always_comb begin
		wr_ok             = 1'b0;
		rd_ok             = 1'b0;
		clr               = 1'b0;
		rsp_nxt.read_data = '0;
		rsp_nxt.status    = cfwp_pkg::STATUS_OK;
		unique case (req.func)
			cfwp_pkg::FUNC_WRITE: begin
				if (fill_q == cap_eff) begin
					rsp_nxt.status = cfwp_pkg::STATUS_FULL;
				end else begin
					wr_ok = 1'b1;
				end
			end
			cfwp_pkg::FUNC_READ: begin
				if (fill_q == '0) begin
					rsp_nxt.status = cfwp_pkg::STATUS_EMPTY;
				end else begin
					rd_ok             = 1'b1;
					rsp_nxt.read_data = cfwp_pkg::WORD_W'(words[0]);
				end
			end
			cfwp_pkg::FUNC_PEEK: begin
				if (req.position == '0 || req.position > fill_q) begin
					rsp_nxt.status = cfwp_pkg::STATUS_BAD_POS;
				end else begin
					rsp_nxt.read_data = cfwp_pkg::WORD_W'(peek_word);
				end
			end
			cfwp_pkg::FUNC_CLEAR: begin
				clr = 1'b1;
			end
			default: begin
				clr = 1'b0;
			end
		endcase
		priority if (clr) begin
			fill_nxt = '0;
		end else if (wr_ok) begin
			fill_nxt = fill_q + 1'b1;
		end else if (rd_ok) begin
			fill_nxt = fill_q - 1'b1;
		end else begin
			fill_nxt = fill_q;
		end
		rsp_nxt.fill_count = fill_nxt;
		rsp_nxt.is_full    = (fill_nxt == cap_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= cfwp_pkg::CAP_RESET;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_accept) begin
				cap_q  <= cfg_data;
				fill_q <= '0;
			end else if (accept) begin
				fill_q <= fill_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`CFWP_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill_q <= cap_eff)
	`CFWP_ASSERT_NEXT(a_write_grows, clk, arst_n, accept && wr_ok && !cfg_accept, fill_q == $past(fill_q) + 1'b1)
	`CFWP_ASSERT_NEXT(a_read_shrinks, clk, arst_n, accept && rd_ok && !cfg_accept, fill_q == $past(fill_q) - 1'b1)
	`CFWP_ASSERT_NEXT(a_cfg_empties, clk, arst_n, cfg_accept, fill_q == '0)
	`CFWP_ASSERT_SAME(a_full_status, clk, arst_n, rsp_valid_q && rsp_q.status == cfwp_pkg::STATUS_FULL, rsp_q.is_full)

endmodule

### design/cfwp_cell.sv
// One storage cell of the FIFO chain: load, shift from neighbor, tap for peek.
module cfwp_cell #(
	parameter int WIDTH = cfwp_pkg::WORD_W
) (
	input  logic                  clk,
	input  cfwp_pkg::cell_ctrl_t  ctrl,
	input  logic [WIDTH-1:0]      write_word,
	input  logic [WIDTH-1:0]      next_word,
	output logic [WIDTH-1:0]      word,
	output logic [WIDTH-1:0]      tap
);

	logic [WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= write_word;
		end else if (ctrl.shift) begin
			data_q <= next_word;
		end
	end

	assign word = data_q;
	assign tap  = ctrl.sel ? data_q : '0;

endmodule

### tb/tb_circular_fifo_with_peek_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the circular FIFO with peek: directed table, then random items.
module tb_circular_fifo_with_peek_unit;

	localparam int RING_DEPTH      = cfwp_pkg::DEPTH_DEF;
	localparam int QUIET_LIMIT     = 4000;
	localparam int ITEMS_PER_PHASE = 145;
	localparam int HOLD_CYCLES     = 300;
	localparam int PHASES          = 12;

	typedef struct {
		cfwp_pkg::req_t op;
		bit             typed;
		cfwp_pkg::rsp_t want;
	} step_row_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       req_valid = 1'b0;
	cfwp_pkg::req_t             req       = '0;
	logic                       rsp_ready = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic [cfwp_pkg::CAP_W-1:0] cfg_data  = '0;
	logic                       req_ready;
	logic                       rsp_valid;
	logic                       cfg_ready;
	cfwp_pkg::rsp_t             rsp;

	logic [cfwp_pkg::WORD_W-1:0] ring_words [RING_DEPTH];
	int                          head_idx;
	int                          tail_idx;
	bit                          ring_full;
	logic [cfwp_pkg::CAP_W-1:0]  cap_reg;

	cfwp_pkg::rsp_t rsp_due [$];
	step_row_t      dir_rows [$];
	bit             row_typed;
	cfwp_pkg::rsp_t row_want;

	int idle_mode;
	int write_pct;
	int hold_asks;
	int errors;
	int n_items;
	int n_caps;
	int n_full_refused;
	int n_empty_refused;
	int n_bad_peeks;
	int n_wrap_peeks;

	logic [cfwp_pkg::CAP_W-1:0] cap_plan [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd7, 5'd31, 5'd2,
		5'd17, 5'd10, 5'd16, 5'd3, 5'd20, 5'd12};

	circular_fifo_with_peek_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int cap_live();
		if (cap_reg == 0) return 1;
		if (cap_reg > RING_DEPTH) return RING_DEPTH;
		return int'(cap_reg);
	endfunction

	function automatic int fill_live();
		if (ring_full) return cap_live();
		if (head_idx >= tail_idx) return head_idx - tail_idx;
		return cap_live() - (tail_idx - head_idx);
	endfunction

	function automatic int step_ptr(int p);
		return (p + 1 >= cap_live()) ? 0 : p + 1;
	endfunction

	function automatic void empty_ring();
		head_idx  = 0;
		tail_idx  = 0;
		ring_full = 1'b0;
	endfunction

	function automatic cfwp_pkg::rsp_t fifo_predict(cfwp_pkg::req_t op);
		cfwp_pkg::rsp_t r;
		int             fill;
		int             cap;
		int             idx;
		r        = '0;
		r.status = cfwp_pkg::STATUS_OK;
		fill     = fill_live();
		cap      = cap_live();
		case (op.func)
			cfwp_pkg::FUNC_WRITE: begin
				if (ring_full) begin
					r.status = cfwp_pkg::STATUS_FULL;
					n_full_refused++;
				end else begin
					ring_words[head_idx] = op.write_value;
					head_idx = step_ptr(head_idx);
					if (head_idx == tail_idx) ring_full = 1'b1;
				end
			end
			cfwp_pkg::FUNC_READ: begin
				if (fill == 0) begin
					r.status = cfwp_pkg::STATUS_EMPTY;
					n_empty_refused++;
				end else begin
					r.read_data = ring_words[tail_idx];
					tail_idx = step_ptr(tail_idx);
					ring_full = 1'b0;
				end
			end
			cfwp_pkg::FUNC_PEEK: begin
				if (op.position < 1 || op.position > fill) begin
					r.status = cfwp_pkg::STATUS_BAD_POS;
					n_bad_peeks++;
				end else begin
					idx = tail_idx + int'(op.position) - 1;
					if (idx >= cap) begin
						idx -= cap;
						n_wrap_peeks++;
					end
					r.read_data = ring_words[idx];
				end
			end
			default: empty_ring();
		endcase
		r.fill_count = cfwp_pkg::FILL_W'(fill_live());
		r.is_full    = ring_full;
		return r;
	endfunction

	function automatic cfwp_pkg::rsp_t mk_rsp(cfwp_pkg::status_t s, int fill, bit full);
		cfwp_pkg::rsp_t r;
		r            = '0;
		r.status     = s;
		r.fill_count = cfwp_pkg::FILL_W'(fill);
		r.is_full    = full;
		return r;
	endfunction

	function automatic step_row_t mk_row(cfwp_pkg::func_t f, logic [cfwp_pkg::WORD_W-1:0] v,
			int pos, bit typed, cfwp_pkg::rsp_t want);
		step_row_t s;
		s.op.func        = f;
		s.op.write_value = v;
		s.op.position    = cfwp_pkg::POS_W'(pos);
		s.typed          = typed;
		s.want           = want;
		return s;
	endfunction

	function automatic cfwp_pkg::req_t random_op();
		cfwp_pkg::req_t op;
		int             fill;
		int             r;
		fill           = fill_live();
		op.write_value = ($urandom_range(9) == 0) ? ($urandom_range(1) ? '1 : '0) : $urandom;
		op.position    = cfwp_pkg::POS_W'($urandom_range(31));
		op.func        = cfwp_pkg::FUNC_PEEK;
		r = $urandom_range(99);
		if (r < 4) begin
			op.func = cfwp_pkg::FUNC_CLEAR;
		end else if (r < 9) begin
			op.func = cfwp_pkg::func_t'($urandom_range(3));
		end else begin
			r = $urandom_range(99);
			if (r < write_pct) op.func = cfwp_pkg::FUNC_WRITE;
			else if (r < write_pct + (100 - write_pct) / 2) op.func = cfwp_pkg::FUNC_READ;
			else if (fill > 0 && $urandom_range(9) < 7)
				op.position = cfwp_pkg::POS_W'($urandom_range(fill, 1));
		end
		return op;
	endfunction

	task automatic flag(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errors++;
	endtask

	// call at a falling edge; returns at the accepting rising edge
	task automatic offer(cfwp_pkg::req_t op, bit typed, cfwp_pkg::rsp_t want);
		row_typed = typed;
		row_want  = want;
		req_valid <= 1'b1;
		req       <= op;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic sender_gap();
		int pct;
		pct = (idle_mode == 0) ? 37 : (idle_mode == 1) ? 55 : 0;
		if ($urandom_range(99) < pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (rsp_due.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_capacity(logic [cfwp_pkg::CAP_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cap_reg = v;
		empty_ring();
		n_caps++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int hold_seen;
		int hold_left;
		int pct;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			pct = (idle_mode == 0) ? 55 : (idle_mode == 1) ? 37 : 0;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= pct);
			end
		end
	end

	initial begin
		int             quiet;
		cfwp_pkg::rsp_t got;
		cfwp_pkg::rsp_t want;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			quiet++;
			if (rsp_valid && rsp_ready) begin
				quiet = 0;
				got   = rsp;
				if (rsp_due.size() == 0) begin
					flag($sformatf("result with nothing pending: %p", got));
				end else begin
					want = rsp_due.pop_front();
					if (got.read_data !== want.read_data)
						flag($sformatf("read_data got %h want %h", got.read_data,
							want.read_data));
					if (got.status !== want.status)
						flag($sformatf("status got %0d want %0d", got.status, want.status));
					if (got.fill_count !== want.fill_count)
						flag($sformatf("fill_count got %0d want %0d", got.fill_count,
							want.fill_count));
					if (got.is_full !== want.is_full)
						flag($sformatf("is_full got %b want %b", got.is_full, want.is_full));
				end
			end
			if (req_valid && req_ready) begin
				quiet = 0;
				want  = fifo_predict(req);
				if (row_typed) want = row_want;
				rsp_due.push_back(want);
				n_items++;
			end
			if (cfg_valid && cfg_ready) quiet = 0;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		cfwp_pkg::req_t op;
		cap_reg   = cfwp_pkg::CAP_RESET;
		empty_ring();
		idle_mode = 0;
		write_pct = 50;
		hold_asks = 0;

		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_READ, 0, 0, 1,
			mk_rsp(cfwp_pkg::STATUS_EMPTY, 0, 0)));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_PEEK, 0, 0, 1,
			mk_rsp(cfwp_pkg::STATUS_BAD_POS, 0, 0)));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_PEEK, 0, 1, 1,
			mk_rsp(cfwp_pkg::STATUS_BAD_POS, 0, 0)));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_CLEAR, 0, 0, 1,
			mk_rsp(cfwp_pkg::STATUS_OK, 0, 0)));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_WRITE, '0, 0, 0, '0));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_WRITE, '1, 31, 0, '0));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_PEEK, 0, 1, 0, '0));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_PEEK, 0, 2, 0, '0));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_PEEK, 0, 3, 0, '0));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_READ, 0, 0, 0, '0));
		for (int i = 0; i < 9; i++)
			dir_rows.push_back(mk_row(cfwp_pkg::FUNC_WRITE, 32'h1357_9bdf * (i + 1), i, 0, '0));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_WRITE, 32'hdead_beef, 0, 1,
			mk_rsp(cfwp_pkg::STATUS_FULL, 10, 1)));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_PEEK, 0, 10, 0, '0));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_PEEK, 0, 31, 0, '0));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_READ, 0, 0, 0, '0));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_CLEAR, 0, 0, 1,
			mk_rsp(cfwp_pkg::STATUS_OK, 0, 0)));
		dir_rows.push_back(mk_row(cfwp_pkg::FUNC_READ, 0, 0, 1,
			mk_rsp(cfwp_pkg::STATUS_EMPTY, 0, 0)));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			sender_gap();
			@(negedge clk);
			offer(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
		end
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_mode = ph / 4;
			set_capacity(cap_plan[ph]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 32 == 0) write_pct = ($urandom_range(2) == 0) ? 15 :
					($urandom_range(1) ? 50 : 85);
				if ((ph == 1 || ph == 9) && n == ITEMS_PER_PHASE / 3) hold_asks++;
				if (ph % 3 == 0 && n == 2 * ITEMS_PER_PHASE / 3) drain();
				sender_gap();
				@(negedge clk);
				op = random_op();
				offer(op, 1'b0, '0);
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (rsp_due.size() != 0) flag($sformatf("%0d results never arrived", rsp_due.size()));
		$display("Covered %0d operations over %0d capacity settings, zero and above-depth included.",
			n_items, n_caps);
		$display("Refusals: %0d write-full, %0d read-empty, %0d bad peek; %0d peeks wrapped.",
			n_full_refused, n_empty_refused, n_bad_peeks, n_wrap_peeks);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/cfwp_pkg.sv
design/cfwp_cell.sv
design/circular_fifo_with_peek_unit.sv
tb/tb_circular_fifo_with_peek_unit.sv
